// ----- rtl/ssvf_pkg.sv -----
// shared types and constants for the stereo state variable filter
`default_nettype none

package ssvf_pkg;

  localparam int COEF_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [COEF_W-1:0] COEF_ONE_RST   = 24'd7647000;
  localparam logic [COEF_W-1:0] COEF_TWO_RST   = 24'd500800;
  localparam logic [COEF_W-1:0] COEF_THREE_RST = 24'd32800;
  localparam logic [COEF_W-1:0] DAMPING_RST    = 24'd1482910;

  typedef enum logic [1:0] {
    MODE_LP     = 2'd0,
    MODE_BP     = 2'd1,
    MODE_HP     = 2'd2,
    MODE_LP_ALT = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_ONE   = 3'd0,
    REG_COEF_TWO   = 3'd1,
    REG_COEF_THREE = 3'd2,
    REG_DAMPING    = 3'd3,
    REG_MODE       = 3'd4,
    REG_CASCADE    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctl_t;

  typedef struct packed {
    logic start;
    logic ack;
  } core_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_sts_t;

endpackage

`default_nettype wire

// ----- rtl/ssvf_mac.sv -----
// shared multiply-accumulate unit: signed operand times unsigned coefficient
`default_nettype none

module ssvf_mac import ssvf_pkg::*; #(
  parameter int OP_W = 33
) (
  input  wire logic                   clk,
  input  wire mac_ctl_t               ctl,
  input  wire logic signed [OP_W-1:0] op,
  input  wire logic [COEF_W-1:0]      coef,
  output logic signed [OP_W+25:0]     acc
);

  logic signed [OP_W+24:0] prod;
  logic signed [OP_W+25:0] acc_r;
  logic signed [OP_W+25:0] acc_nxt;

  assign prod = op * $signed({1'b0, coef});

  always_comb begin
    if (ctl.clr) begin
      acc_nxt = (OP_W+26)'(prod);
    end else begin
      acc_nxt = acc_r + (OP_W+26)'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// ----- rtl/ssvf_core.sv -----
// sequencer, integrator states and tap arithmetic around the shared mac
`default_nettype none

module ssvf_core import ssvf_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int STATE_WIDTH  = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire core_ctl_t                      ctl,
  output core_sts_t                           sts,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_left,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_right,
  input  wire logic [COEF_W-1:0]              coef_one,
  input  wire logic [COEF_W-1:0]              coef_two,
  input  wire logic [COEF_W-1:0]              coef_three,
  input  wire logic [COEF_W-1:0]              damping,
  input  wire mode_t                          filter_mode,
  input  wire logic                           cascade_four,
  output logic signed [SAMPLE_WIDTH-1:0]      y_left,
  output logic signed [SAMPLE_WIDTH-1:0]      y_right
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int TW = STATE_WIDTH;
  localparam int OW = TW + 1;
  localparam int AW = OW + 26;
  localparam int WW = TW + 8;

  localparam logic signed [WW-1:0] ST_MAX = $signed({{(WW-TW+1){1'b0}}, {(TW-1){1'b1}}});
  localparam logic signed [WW-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [TW-1:0] SP_MAX = $signed({{(TW-SW+1){1'b0}}, {(SW-1){1'b1}}});
  localparam logic signed [TW-1:0] SP_MIN = ~SP_MAX;
  localparam logic signed [AW-1:0] RND23  = AW'(1) <<< 22;
  localparam logic signed [AW-1:0] RND20  = AW'(1) <<< 19;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_M1   = 8'b0000_0010,
    S_M2   = 8'b0000_0100,
    S_M3   = 8'b0000_1000,
    S_M4   = 8'b0001_0000,
    S_M5   = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  function automatic logic signed [TW-1:0] sat_state(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] r;
    if (v > ST_MAX) begin
      r = ST_MAX;
    end else if (v < ST_MIN) begin
      r = ST_MIN;
    end else begin
      r = v;
    end
    return TW'(r);
  endfunction

  function automatic logic signed [SW-1:0] sat_sample(input logic signed [TW-1:0] v);
    logic signed [TW-1:0] r;
    if (v > SP_MAX) begin
      r = SP_MAX;
    end else if (v < SP_MIN) begin
      r = SP_MIN;
    end else begin
      r = v;
    end
    return SW'(r);
  endfunction

  state_t state_r, state_nxt;
  logic   ch_r, ch_nxt;
  logic   stage_r, stage_nxt;

  logic signed [SW-1:0] y_r [2];
  logic signed [TW-1:0] integ1_r [4];
  logic signed [TW-1:0] integ2_r [4];
  logic signed [TW-1:0] v1_r;
  logic signed [TW-1:0] v2_r;

  logic [1:0]           idx;
  logic signed [TW-1:0] x_cur;
  logic signed [TW-1:0] s1;
  logic signed [TW-1:0] s2;
  logic signed [OW-1:0] v3;

  mac_ctl_t             mac_ctl;
  logic signed [OW-1:0] mac_op;
  logic [COEF_W-1:0]    mac_coef;
  logic signed [AW-1:0] acc;

  logic signed [AW-1:0] acc23;
  logic signed [AW-1:0] acc20;
  logic signed [AW-24:0] r23;
  logic signed [AW-21:0] r20;
  logic signed [TW-1:0] v1_new;
  logic signed [TW-1:0] v2_new;
  logic signed [TW-1:0] s1_new;
  logic signed [TW-1:0] s2_new;
  logic signed [TW-1:0] hp;
  logic signed [TW-1:0] tap;
  logic signed [SW-1:0] y_new;

  assign idx   = {stage_r, ch_r};
  assign x_cur = TW'(y_r[ch_r]);
  assign s1    = integ1_r[idx];
  assign s2    = integ2_r[idx];
  assign v3    = OW'(x_cur) - OW'(s2);

  // operand and coefficient per step
  always_comb begin
    mac_ctl  = '0;
    mac_op   = OW'(s1);
    mac_coef = coef_one;
    unique case (state_r)
      S_M1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1};
      end
      S_M2: begin
        mac_ctl  = '{en: 1'b1, clr: 1'b0};
        mac_op   = v3;
        mac_coef = coef_two;
      end
      S_M3: begin
        mac_ctl  = '{en: 1'b1, clr: 1'b1};
        mac_coef = coef_two;
      end
      S_M4: begin
        mac_ctl  = '{en: 1'b1, clr: 1'b0};
        mac_op   = v3;
        mac_coef = coef_three;
      end
      S_M5: begin
        mac_ctl  = '{en: 1'b1, clr: 1'b1};
        mac_op   = OW'(v1_r);
        mac_coef = damping;
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  ssvf_mac #(
    .OP_W (OW)
  ) u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op   (mac_op),
    .coef (mac_coef),
    .acc  (acc)
  );

  assign acc23  = acc + RND23;
  assign acc20  = acc + RND20;
  assign r23    = $signed(acc23[AW-1:23]);
  assign r20    = $signed(acc20[AW-1:20]);
  assign v1_new = sat_state(WW'(r23));
  assign v2_new = sat_state(WW'(s2) + WW'(r23));
  assign s1_new = sat_state((WW'(v1_r) <<< 1) - WW'(s1));
  assign s2_new = sat_state((WW'(v2_new) <<< 1) - WW'(s2));
  assign hp     = sat_state(WW'(x_cur) - WW'(r20) - WW'(v2_r));

  always_comb begin
    case (filter_mode) inside
      MODE_BP:              tap = v1_r;
      MODE_HP:              tap = hp;
      MODE_LP, MODE_LP_ALT: tap = v2_r;
      default:              tap = v2_r;
    endcase
  end

  assign y_new = sat_sample(tap);

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    stage_nxt = stage_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          state_nxt = S_M1;
          ch_nxt    = 1'b0;
          stage_nxt = 1'b0;
        end
      end
      S_M1: state_nxt = S_M2;
      S_M2: state_nxt = S_M3;
      S_M3: state_nxt = S_M4;
      S_M4: state_nxt = S_M5;
      S_M5: state_nxt = S_FIN;
      S_FIN: begin
        if (!ch_r) begin
          state_nxt = S_M1;
          ch_nxt    = 1'b1;
        end else if (!stage_r && cascade_four) begin
          state_nxt = S_M1;
          ch_nxt    = 1'b0;
          stage_nxt = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (ctl.ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= 1'b0;
      stage_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        integ1_r[i] <= '0;
        integ2_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      stage_r <= stage_nxt;
      if (state_r == S_M5) begin
        integ1_r[idx] <= s1_new;
        integ2_r[idx] <= s2_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && ctl.start) begin
      y_r[0] <= sample_left;
      y_r[1] <= sample_right;
    end else if (state_r == S_FIN) begin
      y_r[ch_r] <= y_new;
    end
    if (state_r == S_M3) begin
      v1_r <= v1_new;
    end
    if (state_r == S_M5) begin
      v2_r <= v2_new;
    end
  end

  assign sts.idle = (state_r == S_IDLE);
  assign sts.done = (state_r == S_DONE);
  assign y_left   = y_r[0];
  assign y_right  = y_r[1];

  a_start_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && ctl.start) |=> (state_r == S_M1 && !ch_r && !stage_r))
    else $error("pass did not start on left channel of first stage");

  a_pass_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_FIN && state_r != S_IDLE) |=> ($stable(ch_r) && $stable(stage_r)))
    else $error("channel or stage moved mid pass");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !ctl.ack) |=> (state_r == S_DONE && $stable(y_r[0])
      && $stable(y_r[1])))
    else $error("finished result lost before pickup");

endmodule

`default_nettype wire

// ----- rtl/stereo_state_variable_filter.sv -----
// top level of the stereo trapezoidal state variable filter
//
// one stereo pair enters on the in_ stream, one filtered pair leaves on the
// out_ stream. tdata carries the left sample in the low bits, right above it.
// registers are written through cfg_wr_en / cfg_index / cfg_wr_data; the
// user must write them only while no beat is in flight, as the block itself
// does not enforce this. unknown indexes are ignored. each channel pass runs
// on one shared multiply-accumulate unit (five products plus a finishing
// step); a pair takes two passes, four with the four-pole cascade, then the
// result is handed to the output register. in_tready is high only while the
// sequencer idles, so a new pair is accepted only once the last pass is done.
// the result sits in an output register, so a new pair is accepted while the
// last one waits; a stalled out_tready holds out_tdata and the core waits
// only once the next result is finished.
// reset clears all integrator states, loads the default coefficients and
// drops out_tvalid.
`default_nettype none

module stereo_state_variable_filter import ssvf_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int STATE_WIDTH  = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // sample_left, sample_right, zero pad
  input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  in_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // out_left, out_right, zero pad
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       out_tdata,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]                 cfg_index,
  input  wire logic [CFG_DATA_W-1:0]                cfg_wr_data
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int BUSW = ((2*SAMPLE_WIDTH+7)/8)*8;

  logic [COEF_W-1:0] coef_one_r;
  logic [COEF_W-1:0] coef_two_r;
  logic [COEF_W-1:0] coef_three_r;
  logic [COEF_W-1:0] damping_r;
  mode_t             mode_r;
  logic              cascade_r;

  logic              out_valid_r;
  logic [BUSW-1:0]   out_data_r;

  core_ctl_t         core_ctl;
  core_sts_t         core_sts;
  logic signed [SW-1:0] y_left;
  logic signed [SW-1:0] y_right;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_one_r   <= COEF_ONE_RST;
      coef_two_r   <= COEF_TWO_RST;
      coef_three_r <= COEF_THREE_RST;
      damping_r    <= DAMPING_RST;
      mode_r       <= MODE_LP;
      cascade_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COEF_ONE:   coef_one_r   <= cfg_wr_data[COEF_W-1:0];
        REG_COEF_TWO:   coef_two_r   <= cfg_wr_data[COEF_W-1:0];
        REG_COEF_THREE: coef_three_r <= cfg_wr_data[COEF_W-1:0];
        REG_DAMPING:    damping_r    <= cfg_wr_data[COEF_W-1:0];
        REG_MODE:       mode_r       <= mode_t'(cfg_wr_data[1:0]);
        REG_CASCADE:    cascade_r    <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  assign in_tready      = core_sts.idle;
  assign core_ctl.start = in_tvalid & core_sts.idle;
  assign core_ctl.ack   = !out_valid_r || out_tready;

  ssvf_core #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (core_ctl),
    .sts          (core_sts),
    .sample_left  ($signed(in_tdata[SW-1:0])),
    .sample_right ($signed(in_tdata[2*SW-1:SW])),
    .coef_one     (coef_one_r),
    .coef_two     (coef_two_r),
    .coef_three   (coef_three_r),
    .damping      (damping_r),
    .filter_mode  (mode_r),
    .cascade_four (cascade_r),
    .y_left       (y_left),
    .y_right      (y_right)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_sts.done && core_ctl.ack) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_sts.done && core_ctl.ack) begin
      out_data_r <= BUSW'({y_right, y_left});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
